### hw/rtl/crrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrm_pkg: shared definitions for the cascaded range remap block
// Sizes, request codes and the structs that travel between the top level and
// the stage cells.
// ----------------------------------------------------------------------------
package crrm_pkg;

  localparam int STAGES     = 7;
  localparam int ENTRIES    = 64;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int SEL_W = 3;
  localparam int REQ_W = 2;

  // each stage cell registers a compare step, then a select and add step
  localparam int LATENCY = 2 * STAGES;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [VALUE_BITS:0]   bound_t;
  typedef logic [REQ_W-1:0]      req_t;
  typedef logic [SEL_W-1:0]      sel_t;

  localparam req_t REQ_LOAD  = 2'd0;
  localparam req_t REQ_XLATE = 2'd1;
  localparam req_t REQ_CLEAR = 2'd2;

  // entry write into one stage cell
  typedef struct packed {
    logic   we;
    value_t dest;
    value_t src;
    value_t len;
  } load_t;

  // query value handed from cell to cell
  typedef struct packed {
    logic   valid;
    value_t value;
  } link_t;

endpackage

### hw/rtl/crrm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrm_req_if / crrm_rsp_if: request and response channels
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface crrm_req_if;
  import crrm_pkg::*;
  logic   valid;
  logic   ready;
  req_t   req_type;
  sel_t   stage_sel;
  value_t dest_start;
  value_t src_start;
  value_t range_len;
  value_t query_value;

  modport source (output valid, req_type, stage_sel, dest_start, src_start, range_len,
                  query_value, input ready);
  modport sink   (input valid, req_type, stage_sel, dest_start, src_start, range_len,
                  query_value, output ready);
endinterface

interface crrm_rsp_if;
  import crrm_pkg::*;
  logic   valid;
  logic   ready;
  value_t final_value;
  value_t min_value;

  modport source (output valid, final_value, min_value, input ready);
  modport sink   (input valid, final_value, min_value, output ready);
endinterface

### hw/rtl/crrm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrm_cell: one translation stage of the chain
// Holds one stage's range entries, compares the incoming value against all
// of them, then applies the first hit in load order.
// ----------------------------------------------------------------------------
module crrm_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  crrm_pkg::load_t load_i,
  input  logic            clear_i,
  input  crrm_pkg::link_t link_i,
  output crrm_pkg::link_t link_o
);
  import crrm_pkg::*;

  // entry storage: start, exclusive end (33 bits, no wrap) and dest - src
  value_t           src_q [ENTRIES];
  bound_t           end_q [ENTRIES];
  value_t           off_q [ENTRIES];
  logic [CNT_W-1:0] cnt_q;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;

  logic               a_valid_q;
  value_t             a_value_q;
  logic [ENTRIES-1:0] hit_d, hit_q;

  logic [ENTRIES-1:0] first_hit;
  value_t             sel_off;
  link_t              link_d, link_q;

  assign wr_en  = load_i.we && (cnt_q < CNT_W'(ENTRIES));
  assign wr_idx = cnt_q[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (clear_i) begin
      cnt_q <= '0;
    end else if (wr_en) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      src_q[wr_idx] <= load_i.src;
      end_q[wr_idx] <= {1'b0, load_i.src} + {1'b0, load_i.len};
      off_q[wr_idx] <= load_i.dest - load_i.src;
    end
  end

  // compare step: every filled entry at once
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_d[i] = (CNT_W'(i) < cnt_q) && (link_i.value >= src_q[i])
                 && ({1'b0, link_i.value} < end_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= link_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    a_value_q <= link_i.value;
    hit_q     <= hit_d;
  end

  // select step: lowest index hit wins
  assign first_hit = hit_q & (~hit_q + 1'b1);

  always_comb begin
    sel_off = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel_off = sel_off | (off_q[i] & {VALUE_BITS{first_hit[i]}});
    end
  end

  assign link_d.valid = a_valid_q;
  assign link_d.value = a_value_q + sel_off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else begin
      link_q <= link_d;
    end
  end

  assign link_o = link_q;

endmodule

### hw/rtl/cascaded_range_remap_min.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_range_remap_min: multistage range translation with running minimum
// Seven chained stage cells map a query value through per-stage range lists
// and report the final value together with the smallest value seen so far.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one transaction per request: req_type selects load entry,
//   translate value or clear. Loads append (dest, src, len) to stage
//   stage_sel; a full stage or a stage number past the last drops the entry.
//   Clear empties all stages and sets the minimum to all ones.
//   rsp_o returns one transaction per translate request (final_value,
//   min_value); loads and clears return nothing.
// Pipeline and throughput:
//   Each stage cell registers a compare step over all entries, then a select
//   step that takes the first hit and adds its offset; after the cell chain a
//   translation passes a completion register and then the output register.
//   A translation holds off every further request until its result moves into
//   the output register; loads and clears do not hold off further requests.
// Reset and stalls:
//   Reset empties every stage and sets the minimum to all ones; entry
//   storage is not cleared and needs no clearing pass. A stalled receiver
//   holds the output register; the block still takes loads and clears, and
//   a further translation waits in the completion register until the output
//   register frees up.
// ----------------------------------------------------------------------------
module cascaded_range_remap_min (
  input  logic       clk_i,
  input  logic       rst_ni,
  crrm_req_if.sink   req_i,
  crrm_rsp_if.source rsp_o
);
  import crrm_pkg::*;

  logic req_acc;
  logic acc_load;
  logic acc_xlate;
  logic acc_clear;

  load_t load  [STAGES];
  link_t chain [STAGES+1];

  // one translation in flight until its result reaches the output register
  logic   busy_q;
  logic   pend_valid_q;
  value_t pend_value_q;
  logic   move;

  logic   out_valid_q;
  value_t out_final_q;
  value_t out_min_q;
  value_t min_q;
  value_t min_d;

  assign req_i.ready = !busy_q;
  assign req_acc     = req_i.valid && req_i.ready;
  assign acc_load    = req_acc && (req_i.req_type == REQ_LOAD);
  assign acc_xlate   = req_acc && (req_i.req_type == REQ_XLATE);
  assign acc_clear   = req_acc && (req_i.req_type == REQ_CLEAR);

  // head of the chain takes the query straight from the channel
  assign chain[0].valid = acc_xlate;
  assign chain[0].value = req_i.query_value;

  for (genvar s = 0; s < STAGES; s++) begin : g_cell
    assign load[s].we   = acc_load && (req_i.stage_sel == SEL_W'(s));
    assign load[s].dest = req_i.dest_start;
    assign load[s].src  = req_i.src_start;
    assign load[s].len  = req_i.range_len;

    crrm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (load[s]),
      .clear_i (acc_clear),
      .link_i  (chain[s]),
      .link_o  (chain[s+1])
    );
  end

  // completion register to output register when the output side is free
  assign move  = pend_valid_q && (!out_valid_q || rsp_o.ready);
  assign min_d = (pend_value_q < min_q) ? pend_value_q : min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      min_q        <= '1;
    end else begin
      if (acc_xlate) begin
        busy_q <= 1'b1;
      end else if (move) begin
        busy_q <= 1'b0;
      end

      if (chain[STAGES].valid) begin
        pend_valid_q <= 1'b1;
      end else if (move) begin
        pend_valid_q <= 1'b0;
      end

      if (move) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (acc_clear) begin
        min_q <= '1;
      end else if (move) begin
        min_q <= min_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain[STAGES].valid) begin
      pend_value_q <= chain[STAGES].value;
    end
    if (move) begin
      out_final_q <= pend_value_q;
      out_min_q   <= min_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.final_value = out_final_q;
  assign rsp_o.min_value   = out_min_q;

  // every accepted translation comes out at the end of the cell chain
  a_chain_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_xlate |-> ##(LATENCY) chain[STAGES].valid)
    else $error("translation did not leave the cell chain on time");

  // the reported minimum includes the value it is reported with
  a_min_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.min_value <= rsp_o.final_value))
    else $error("minimum above its own final value");

  // clear restores the minimum to all ones
  a_clear_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_clear |=> (min_q == '1))
    else $error("clear did not reset the running minimum");

endmodule
